[hdl/image_mse_metric_unit_macros.svh]
// assertion macros for the image error metric unit
// no dependencies
`ifndef IMAGE_MSE_METRIC_UNIT_MACROS_SVH
`define IMAGE_MSE_METRIC_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MSE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define MSE_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MSE_ASSERT(label, clk, rst_n, prop, msg)
`define MSE_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[hdl/imse_pkg.sv]
// types and constants for the image error metric unit
// no dependencies
`default_nettype none
package imse_pkg;
    localparam int FRACTION_BITS = 16;

    typedef enum logic [0:0] {
        CFG_METRIC_MODE = 1'b0,
        CFG_RELATIVE_EPSILON = 1'b1
    } t_cfg_index;

    localparam logic [31:0] EPSILON_RESET = 32'd655;

    typedef struct packed {
        logic [31:0] ref_red_sum;
        logic [31:0] ref_green_sum;
        logic [31:0] ref_blue_sum;
        logic [15:0] ref_sample_count;
        logic [31:0] cand_red_sum;
        logic [31:0] cand_green_sum;
        logic [31:0] cand_blue_sum;
        logic [15:0] cand_sample_count;
        logic        last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [31:0] error_value;
        logic [31:0] pixels_counted;
        logic        saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_REF,
        ST_DIV_CAND,
        ST_MUL_D,
        ST_MUL_R,
        ST_DIV_TERM,
        ST_ADD,
        ST_FINAL_MUL,
        ST_FINAL_DIV,
        ST_EMIT
    } t_state;
endpackage
`default_nettype wire

[hdl/image_mse_metric_unit.sv]
// top level of the image error metric unit
// depends on imse_pkg, imse_divider and image_mse_metric_unit_macros.svh
`default_nettype none
`include "image_mse_metric_unit_macros.svh"
// Compares two accumulated images one pixel pair per request. Each channel is
// normalized by its sample count, differenced and squared; mode 0 adds d*d >> 16,
// mode 1 adds d*d / (r*r >> 16 + epsilon). A pair with a zero count is skipped, and
// unless it is the last pixel the next request can follow at once. A counted pair
// runs its divisions through the single shared 64-bit divider, which retires one
// quotient bit per cycle (two divisions per channel, a third in mode 1 when the
// denominator is nonzero). The last pixel adds a multiply, one division (skipped
// when nothing was counted) and the emit step for total / (3*counted), then the
// result sits in an output register until taken. Input stall is high whenever busy.
module image_mse_metric_unit
    import imse_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic        r_mode;
    logic [31:0] r_eps;
    logic [63:0] r_total, n_total;
    logic [31:0] r_counted, n_counted;
    logic        r_ovf, n_ovf;
    logic [1:0]  r_ch, n_ch;
    logic [31:0] r_nref, n_nref;
    logic [63:0] r_a, n_a;          // squared difference
    logic [63:0] r_b, n_b;          // denominator or term
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // shared divider
    logic        w_div_start;
    logic [63:0] w_div_num, w_div_den, w_quo;
    logic        w_div_done;

    imse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    logic        r_wait, n_wait;    // a division is in flight
    logic [31:0] w_ref_sum, w_cand_sum;
    logic [64:0] w_add;
    logic [63:0] w_mul;
    logic [31:0] w_mul_x, w_mul_y;

    // shared 32x32 multiplier, one product per cycle
    assign w_mul = 64'(w_mul_x) * 64'(w_mul_y);

    always_comb begin
        unique case (r_ch)
            2'd0:    begin w_ref_sum = r_item.ref_red_sum;   w_cand_sum = r_item.cand_red_sum;   end
            2'd1:    begin w_ref_sum = r_item.ref_green_sum; w_cand_sum = r_item.cand_green_sum; end
            default: begin w_ref_sum = r_item.ref_blue_sum;  w_cand_sum = r_item.cand_blue_sum;  end
        endcase
    end

    assign w_add = {1'b0, r_total} + {1'b0, r_b};

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_total     = r_total;
        n_counted   = r_counted;
        n_ovf       = r_ovf;
        n_ch        = r_ch;
        n_nref      = r_nref;
        n_a         = r_a;
        n_b         = r_b;
        n_wait      = r_wait;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = 64'd1;
        w_mul_x     = '0;
        w_mul_y     = '0;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    n_ch   = 2'd0;
                    if (i_in_data.ref_sample_count != 16'd0 &&
                        i_in_data.cand_sample_count != 16'd0) begin
                        n_state = ST_DIV_REF;
                    end else if (i_in_data.last_pixel) begin
                        n_state = ST_FINAL_MUL;
                    end
                end
            end
            ST_DIV_REF: begin
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    w_div_num   = {32'd0, w_ref_sum};
                    w_div_den   = {48'd0, r_item.ref_sample_count};
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_nref  = w_quo[31:0];
                    n_wait  = 1'b0;
                    n_state = ST_DIV_CAND;
                end
            end
            ST_DIV_CAND: begin
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    w_div_num   = {32'd0, w_cand_sum};
                    w_div_den   = {48'd0, r_item.cand_sample_count};
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    // hold |c - r| in the low half of r_a for the square
                    n_a     = {32'd0, (w_quo[31:0] >= r_nref) ? (w_quo[31:0] - r_nref)
                                                            : (r_nref - w_quo[31:0])};
                    n_wait  = 1'b0;
                    n_state = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                w_mul_x = r_a[31:0];
                w_mul_y = r_a[31:0];
                n_a     = w_mul;
                if (!r_mode) begin
                    n_b     = w_mul >> FRACTION_BITS;
                    n_state = ST_ADD;
                end else begin
                    n_state = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                w_mul_x = r_nref;
                w_mul_y = r_nref;
                n_b     = (w_mul >> FRACTION_BITS) + 64'(r_eps);
                n_state = ST_DIV_TERM;
            end
            ST_DIV_TERM: begin
                if (r_b == 64'd0) begin
                    if (r_a != 64'd0) begin
                        n_total = '1;
                        n_ovf   = 1'b1;
                        n_b     = '0;
                        n_state = ST_ADD;
                    end else begin
                        n_state = ST_ADD;
                    end
                end else if (!r_wait) begin
                    w_div_start = 1'b1;
                    w_div_num   = r_a;
                    w_div_den   = r_b;
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_b     = w_quo;
                    n_wait  = 1'b0;
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                if (w_add[64]) begin
                    n_total = '1;
                    n_ovf   = 1'b1;
                end else begin
                    n_total = w_add[63:0];
                end
                if (r_ch == 2'd2) begin
                    if (r_counted == '1) n_ovf = 1'b1;
                    else n_counted = r_counted + 32'd1;
                    n_state = r_item.last_pixel ? ST_FINAL_MUL : ST_IDLE;
                end else begin
                    n_ch    = r_ch + 2'd1;
                    n_state = ST_DIV_REF;
                end
            end
            ST_FINAL_MUL: begin
                w_mul_x = r_counted;
                w_mul_y = 32'd3;
                n_b     = w_mul;
                n_state = (r_counted == 32'd0) ? ST_EMIT : ST_FINAL_DIV;
            end
            ST_FINAL_DIV: begin
                if (!r_wait) begin
                    w_div_start = 1'b1;
                    w_div_num   = r_total;
                    w_div_den   = r_b;
                    n_wait      = 1'b1;
                end else if (w_div_done) begin
                    n_wait = 1'b0;
                    n_b    = w_quo;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait for the output register to drain
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.pixels_counted = r_counted;
                    if (r_counted == 32'd0) begin
                        n_out.error_value = '0;
                        n_out.saturated   = r_ovf;
                    end else if (r_b[63:32] != 32'd0) begin
                        n_out.error_value = '1;
                        n_out.saturated   = 1'b1;
                    end else begin
                        n_out.error_value = r_b[31:0];
                        n_out.saturated   = r_ovf;
                    end
                    n_total   = '0;
                    n_counted = '0;
                    n_ovf     = 1'b0;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_counted   <= '0;
            r_ovf       <= 1'b0;
            r_wait      <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_eps       <= EPSILON_RESET;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_counted   <= n_counted;
            r_ovf       <= n_ovf;
            r_wait      <= n_wait;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_METRIC_MODE:      r_mode <= i_cfg_data[0];
                    CFG_RELATIVE_EPSILON: r_eps  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_item     <= n_item;
        r_ch       <= n_ch;
        r_nref     <= n_nref;
        r_a        <= n_a;
        r_b        <= n_b;
        r_out      <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a request is only taken while idle; a divider result only comes while one is in flight
    `MSE_ASSERT(a_div_only_when_waiting, i_clk, i_rst_n, w_div_done |-> r_wait,
        "divider result with no division in flight")
    `MSE_ASSERT(a_out_holds, i_clk, i_rst_n, (o_out_valid && i_out_stall) |=> $stable(o_out_data),
        "stalled result changed")
    `MSE_ASSERT(a_cleared_after_emit, i_clk, i_rst_n,
        (r_state == ST_EMIT && n_state == ST_IDLE) |=> (r_counted == 32'd0 && !r_ovf),
        "state not cleared after result")
    `MSE_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall),
        "not idle after reset")
endmodule
`default_nettype wire

[hdl/imse_divider.sv]
// restoring radix-2 divider, 64 by 64 bits, one quotient bit a cycle
// uses imse_pkg only for the house import
`default_nettype none
module imse_divider
    import imse_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [63:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_div, n_div;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [64:0] w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[63]} - {1'b0, r_div};
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
            n_cnt  = 7'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_trial[64]) begin
                n_rem = w_trial[63:0];
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = {r_rem[62:0], r_quo[63]};
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire
